>>> src/transfer_function_lut_interp_core_defines.svh
// ----------------------------------------------------------------------------
// Transfer function LUT core - assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef TRANSFER_FUNCTION_LUT_INTERP_CORE_DEFINES_SVH
`define TRANSFER_FUNCTION_LUT_INTERP_CORE_DEFINES_SVH

// same-cycle implication
`define TFLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tfli_pkg.sv
// ----------------------------------------------------------------------------
// Transfer function LUT package
// Widths, codes, payload structs and state types shared by the block.
// ----------------------------------------------------------------------------
package tfli_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 1024;
    localparam int MAX_POINTS_DEFAULT    = 16;

    localparam int ISO_W       = 10;
    localparam int CHAN_W      = 16;
    localparam int SAMPLE_W    = 24;
    localparam int FRAC_W      = 8;
    localparam int TOP_W       = 10;
    localparam int DMAX_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SCALED_W    = SAMPLE_W + TOP_W;
    localparam int NUM_LANES   = 3;
    localparam int CPT_W       = ISO_W + 3 * CHAN_W;
    localparam int APT_W       = ISO_W + CHAN_W;

    localparam logic [TOP_W-1:0]  TOP_RESET  = TOP_W'(255);
    localparam logic [DMAX_W-1:0] DMAX_RESET = DMAX_W'(255);

    typedef enum logic [1:0] {
        MODE_ADD_COLOUR = 2'd0,
        MODE_ADD_ALPHA  = 2'd1,
        MODE_CLEAR      = 2'd2,
        MODE_LOOKUP     = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOP_INDEX    = 2'd0,
        CFG_SCALE_ENABLE = 2'd1,
        CFG_DATA_MAXIMUM = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        mode_t                mode;
        logic [ISO_W-1:0]     iso_value;
        logic [CHAN_W-1:0]    red;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    blue;
        logic [CHAN_W-1:0]    alpha_level;
        logic [SAMPLE_W-1:0]  sample;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              in_range;
    } out_item_t;

    typedef struct packed {
        logic rgb_we;
        logic alpha_we;
    } tbl_wr_t;

    typedef enum logic [3:0] {
        CTL_IDLE,
        CTL_BUILD,
        CTL_SCALE,
        CTL_DIV_START,
        CTL_DIV_WAIT,
        CTL_RANGE,
        CTL_RD_NEXT,
        CTL_CAP_HI,
        CTL_MIX
    } ctl_state_t;

    typedef enum logic [3:0] {
        BLD_IDLE,
        BLD_CLEAR,
        BLD_LIST,
        BLD_FIRST,
        BLD_NEXT,
        BLD_DIV_GO,
        BLD_DIV,
        BLD_WALK,
        BLD_ADVANCE,
        BLD_DONE
    } bld_state_t;

endpackage

>>> src/tfli_ram.sv
// ----------------------------------------------------------------------------
// Transfer function LUT RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tfli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/tfli_div.sv
// ----------------------------------------------------------------------------
// Transfer function LUT divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfli_div #(
    parameter int DW = 16,
    parameter int VW = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VW:0]      trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? VW'(trial - {1'b0, dvs_reg}) : VW'(trial);
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/tfli_build.sv
// ----------------------------------------------------------------------------
// Transfer function LUT table builder
// Clears the table, then walks each control point pair, writing entries
// with an incremental quotient/remainder interpolator.
// ----------------------------------------------------------------------------
module tfli_build #(
    parameter int TABLE_ENTRIES = tfli_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int MAX_POINTS    = tfli_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [tfli_pkg::TOP_W-1:0]             top,
    input  logic [$clog2(MAX_POINTS+1)-1:0]        colour_count,
    input  logic [$clog2(MAX_POINTS+1)-1:0]        alpha_count,
    output logic [$clog2(MAX_POINTS)-1:0]          pt_raddr,
    input  logic [tfli_pkg::CPT_W-1:0]             colour_rdata,
    input  logic [tfli_pkg::APT_W-1:0]             alpha_rdata,
    output tfli_pkg::tbl_wr_t                      wr,
    output logic [$clog2(TABLE_ENTRIES)-1:0]       wr_addr,
    output logic [3*tfli_pkg::CHAN_W-1:0]          wr_rgb,
    output logic [tfli_pkg::CHAN_W-1:0]            wr_alpha,
    output logic                                   done
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = tfli_pkg::ISO_W;
    localparam int CH  = tfli_pkg::CHAN_W;
    localparam int XW  = tfli_pkg::TOP_W + 1;
    localparam int NL  = tfli_pkg::NUM_LANES;

    tfli_pkg::bld_state_t state_reg, state_next;

    logic          list_reg;          // 0 colour list, 1 alpha list
    logic [CW-1:0] idx_reg;           // index of upper point of current pair
    logic [XW-1:0] x_reg;
    logic [IW-1:0] i0_reg, i1_reg;
    logic [CH-1:0] c0_reg [NL];
    logic [CH-1:0] c1_reg [NL];
    logic [CH-1:0] q_reg  [NL];
    logic [CH-1:0] qd_reg [NL];
    logic [IW-1:0] r_reg  [NL];
    logic [IW-1:0] rd_reg [NL];

    logic [CW-1:0] count_sel;
    logic [IW-1:0] pt_iso;
    logic [CH-1:0] pt_chan [NL];
    logic [IW-1:0] seg_len;
    logic          in_seg;
    logic          div_start;
    logic [NL-1:0] div_done;
    logic [CH-1:0] div_q   [NL];
    logic [IW-1:0] div_r   [NL];
    logic [NL-1:0] neg;
    logic [CH-1:0] mag     [NL];

    assign count_sel = list_reg ? alpha_count : colour_count;
    assign seg_len   = i1_reg - i0_reg;
    assign in_seg    = (x_reg <= {1'b0, i1_reg}) && (x_reg <= {1'b0, top});

    always_comb begin
        if (list_reg) begin
            pt_iso     = alpha_rdata[CH +: IW];
            pt_chan[0] = alpha_rdata[CH-1:0];
            pt_chan[1] = '0;
            pt_chan[2] = '0;
        end else begin
            pt_iso     = colour_rdata[3*CH +: IW];
            pt_chan[0] = colour_rdata[2*CH +: CH];
            pt_chan[1] = colour_rdata[CH +: CH];
            pt_chan[2] = colour_rdata[0 +: CH];
        end
    end

    // per-lane slope division: |c1 - c0| / d, sign fixed up afterwards
    for (genvar k = 0; k < NL; k++) begin : g_lane
        logic [CH:0] delta;
        assign delta  = {1'b0, c1_reg[k]} - {1'b0, c0_reg[k]};
        assign neg[k] = delta[CH];
        assign mag[k] = neg[k] ? CH'(-delta) : delta[CH-1:0];

        tfli_div #(
            .DW (CH),
            .VW (IW)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (div_start),
            .dividend  (mag[k]),
            .divisor   (seg_len),
            .done      (div_done[k]),
            .quotient  (div_q[k]),
            .remainder (div_r[k])
        );
    end

    always_comb begin
        state_next = state_reg;
        pt_raddr   = '0;
        wr         = '0;
        div_start  = 1'b0;
        done       = 1'b0;
        case (state_reg)
            tfli_pkg::BLD_IDLE: begin
                if (start) begin
                    state_next = tfli_pkg::BLD_CLEAR;
                end
            end
            tfli_pkg::BLD_CLEAR: begin
                wr.rgb_we   = 1'b1;
                wr.alpha_we = 1'b1;
                if (x_reg == {1'b0, top}) begin
                    state_next = tfli_pkg::BLD_LIST;
                end
            end
            tfli_pkg::BLD_LIST: begin
                if (count_sel >= CW'(2)) begin
                    state_next = tfli_pkg::BLD_FIRST;
                end else if (list_reg) begin
                    state_next = tfli_pkg::BLD_DONE;
                end
            end
            tfli_pkg::BLD_FIRST: begin
                pt_raddr   = PW'(1);
                state_next = tfli_pkg::BLD_NEXT;
            end
            tfli_pkg::BLD_NEXT: begin
                state_next = tfli_pkg::BLD_DIV_GO;
            end
            tfli_pkg::BLD_DIV_GO: begin
                if (i0_reg > i1_reg) begin
                    state_next = tfli_pkg::BLD_ADVANCE;
                end else begin
                    div_start  = 1'b1;
                    state_next = tfli_pkg::BLD_DIV;
                end
            end
            tfli_pkg::BLD_DIV: begin
                if (div_done[0]) begin
                    state_next = tfli_pkg::BLD_WALK;
                end
            end
            tfli_pkg::BLD_WALK: begin
                if (in_seg) begin
                    wr.rgb_we   = !list_reg;
                    wr.alpha_we = list_reg;
                end else begin
                    state_next = tfli_pkg::BLD_ADVANCE;
                end
            end
            tfli_pkg::BLD_ADVANCE: begin
                if (CW'(idx_reg + CW'(1)) < count_sel) begin
                    pt_raddr   = PW'(idx_reg + CW'(1));
                    state_next = tfli_pkg::BLD_NEXT;
                end else if (list_reg) begin
                    state_next = tfli_pkg::BLD_DONE;
                end else begin
                    state_next = tfli_pkg::BLD_LIST;
                end
            end
            tfli_pkg::BLD_DONE: begin
                done       = 1'b1;
                state_next = tfli_pkg::BLD_IDLE;
            end
            default: begin
                state_next = tfli_pkg::BLD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tfli_pkg::BLD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        logic [IW:0] rsum;
        case (state_reg)
            tfli_pkg::BLD_IDLE: begin
                x_reg    <= '0;
                list_reg <= 1'b0;
            end
            tfli_pkg::BLD_CLEAR: begin
                x_reg <= x_reg + XW'(1);
            end
            tfli_pkg::BLD_LIST: begin
                if (count_sel < CW'(2)) begin
                    list_reg <= 1'b1;
                end
            end
            tfli_pkg::BLD_FIRST: begin
                i0_reg  <= pt_iso;
                c0_reg  <= pt_chan;
                idx_reg <= CW'(1);
            end
            tfli_pkg::BLD_NEXT: begin
                i1_reg <= pt_iso;
                c1_reg <= pt_chan;
            end
            tfli_pkg::BLD_DIV: begin
                for (int k = 0; k < NL; k++) begin
                    if (!neg[k]) begin
                        qd_reg[k] <= div_q[k];
                        rd_reg[k] <= div_r[k];
                    end else if (div_r[k] == '0) begin
                        qd_reg[k] <= CH'(-div_q[k]);
                        rd_reg[k] <= '0;
                    end else begin
                        qd_reg[k] <= ~div_q[k];
                        rd_reg[k] <= seg_len - div_r[k];
                    end
                    q_reg[k] <= c0_reg[k];
                    r_reg[k] <= seg_len >> 1;
                end
                x_reg <= {1'b0, i0_reg};
            end
            tfli_pkg::BLD_WALK: begin
                x_reg <= x_reg + XW'(1);
                for (int k = 0; k < NL; k++) begin
                    rsum = {1'b0, r_reg[k]} + {1'b0, rd_reg[k]};
                    if (rsum >= {1'b0, seg_len}) begin
                        r_reg[k] <= IW'(rsum - {1'b0, seg_len});
                        q_reg[k] <= q_reg[k] + qd_reg[k] + CH'(1);
                    end else begin
                        r_reg[k] <= rsum[IW-1:0];
                        q_reg[k] <= q_reg[k] + qd_reg[k];
                    end
                end
            end
            tfli_pkg::BLD_ADVANCE: begin
                i0_reg <= i1_reg;
                c0_reg <= c1_reg;
                if (CW'(idx_reg + CW'(1)) < count_sel) begin
                    idx_reg <= idx_reg + CW'(1);
                end else begin
                    list_reg <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign wr_addr  = AW'(x_reg);
    assign wr_rgb   = (state_reg == tfli_pkg::BLD_CLEAR) ? '0 : {q_reg[0], q_reg[1], q_reg[2]};
    assign wr_alpha = (state_reg == tfli_pkg::BLD_CLEAR) ? '0 : q_reg[0];

endmodule

>>> src/transfer_function_lut_interp_core.sv
// ----------------------------------------------------------------------------
// Transfer function LUT interpolation core
// Piecewise-linear RGBA transfer function with a lazily rebuilt table.
// ----------------------------------------------------------------------------
// Transactions on s_ add a colour or alpha control point, clear both lists
// or look up a Q16.8 sample; only lookups return a transaction on m_. A
// lookup reads the lower and then the upper table entry through the table
// RAMs' single read port and interpolates them; an out-of-range sample
// skips the reads. With scaling enabled the sample first passes through
// the 34-step sample divider. The first lookup after a point change or a
// top_index write first rebuilds the table: it clears entries 0 to the top
// index, then per control point pair runs the 16-step slope divider and
// writes the pair's table entries. The next input is accepted once a
// lookup has moved its result into the output register. No clearing pass
// is needed after reset: a rebuild zeroes entries 0 to the top index
// before any lookup reads the table.
// ----------------------------------------------------------------------------
module transfer_function_lut_interp_core #(
    parameter int TABLE_ENTRIES = tfli_pkg::TABLE_ENTRIES_DEFAULT,  // power of two
    parameter int MAX_POINTS    = tfli_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tfli_pkg::in_item_t                  s_data,
    // result transactions
    output logic                                m_valid,
    input  logic                                m_ready,
    output tfli_pkg::out_item_t                 m_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tfli_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tfli_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int CH  = tfli_pkg::CHAN_W;
    localparam int TW  = tfli_pkg::TOP_W;
    localparam int SW  = tfli_pkg::SCALED_W;
    localparam int FW  = tfli_pkg::FRAC_W;
    localparam int TOP_LIMIT = (TABLE_ENTRIES - 1 < (1 << TW) - 1) ?
                               TABLE_ENTRIES - 1 : (1 << TW) - 1;

    // configuration registers
    logic [TW-1:0]               top_index_reg;
    logic                        scale_enable_reg;
    logic [tfli_pkg::DMAX_W-1:0] data_maximum_reg;

    // point list and table state
    logic [CW-1:0] colour_count_reg;
    logic [CW-1:0] alpha_count_reg;
    logic          table_valid_reg;

    // lookup datapath
    tfli_pkg::ctl_state_t state_reg, state_next;
    logic [SW-1:0]     sample_reg;      // raw, then product, then scaled sample
    logic              range_reg;
    logic [3*CH-1:0]   e0_rgb_reg, e1_rgb_reg;
    logic [CH-1:0]     e0_a_reg, e1_a_reg;
    logic              m_valid_reg;
    tfli_pkg::out_item_t m_data_reg;

    logic [TW-1:0]     eff_top;
    logic              s_fire;
    logic              out_load;
    logic              bld_start, bld_done;
    logic              div_start, div_done;
    logic [SW-1:0]     div_q;
    logic [tfli_pkg::DMAX_W-1:0] div_r;
    logic [AW-1:0]     ent_n;
    logic [AW-1:0]     tbl_raddr;
    logic [FW-1:0]     frac;

    // point memories
    logic                      cpt_we, apt_we;
    logic [PW-1:0]             pt_raddr;
    logic [tfli_pkg::CPT_W-1:0] cpt_rdata;
    logic [tfli_pkg::APT_W-1:0] apt_rdata;

    // table memories, colour and alpha kept apart so each pass writes blind
    tfli_pkg::tbl_wr_t tbl_wr;
    logic [AW-1:0]     tbl_waddr;
    logic [3*CH-1:0]   tbl_wrgb, tbl_rgb;
    logic [CH-1:0]     tbl_walpha, tbl_alpha;

    assign eff_top  = (int'(top_index_reg) > TOP_LIMIT) ? TW'(TOP_LIMIT) : top_index_reg;
    assign s_ready  = (state_reg == tfli_pkg::CTL_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign cpt_we = s_fire && (s_data.mode == tfli_pkg::MODE_ADD_COLOUR) &&
                    (colour_count_reg < CW'(MAX_POINTS));
    assign apt_we = s_fire && (s_data.mode == tfli_pkg::MODE_ADD_ALPHA) &&
                    (alpha_count_reg < CW'(MAX_POINTS));

    // integer part selects the lower entry; upper entry wraps like the index mask
    assign ent_n     = sample_reg[FW +: AW];
    assign frac      = sample_reg[FW-1:0];
    assign tbl_raddr = (state_reg == tfli_pkg::CTL_RD_NEXT) ? AW'(ent_n + AW'(1)) : ent_n;

    tfli_ram #(
        .WIDTH (tfli_pkg::CPT_W),
        .DEPTH (MAX_POINTS)
    ) u_colour_pts (
        .aclk  (aclk),
        .we    (cpt_we),
        .waddr (PW'(colour_count_reg)),
        .wdata ({s_data.iso_value, s_data.red, s_data.green, s_data.blue}),
        .raddr (pt_raddr),
        .rdata (cpt_rdata)
    );

    tfli_ram #(
        .WIDTH (tfli_pkg::APT_W),
        .DEPTH (MAX_POINTS)
    ) u_alpha_pts (
        .aclk  (aclk),
        .we    (apt_we),
        .waddr (PW'(alpha_count_reg)),
        .wdata ({s_data.iso_value, s_data.alpha_level}),
        .raddr (pt_raddr),
        .rdata (apt_rdata)
    );

    tfli_ram #(
        .WIDTH (3 * CH),
        .DEPTH (TABLE_ENTRIES)
    ) u_rgb_table (
        .aclk  (aclk),
        .we    (tbl_wr.rgb_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wrgb),
        .raddr (tbl_raddr),
        .rdata (tbl_rgb)
    );

    tfli_ram #(
        .WIDTH (CH),
        .DEPTH (TABLE_ENTRIES)
    ) u_alpha_table (
        .aclk  (aclk),
        .we    (tbl_wr.alpha_we),
        .waddr (tbl_waddr),
        .wdata (tbl_walpha),
        .raddr (tbl_raddr),
        .rdata (tbl_alpha)
    );

    tfli_build #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_POINTS    (MAX_POINTS)
    ) u_build (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (bld_start),
        .top          (eff_top),
        .colour_count (colour_count_reg),
        .alpha_count  (alpha_count_reg),
        .pt_raddr     (pt_raddr),
        .colour_rdata (cpt_rdata),
        .alpha_rdata  (apt_rdata),
        .wr           (tbl_wr),
        .wr_addr      (tbl_waddr),
        .wr_rgb       (tbl_wrgb),
        .wr_alpha     (tbl_walpha),
        .done         (bld_done)
    );

    // sample scaling: product / data_maximum
    tfli_div #(
        .DW (SW),
        .VW (tfli_pkg::DMAX_W)
    ) u_scale_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sample_reg),
        .divisor   (data_maximum_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // (e0*(256-f) + e1*f + 128) >> 8, rounds half up
    function automatic logic [CH-1:0] mix(input logic [CH-1:0] e0,
                                          input logic [CH-1:0] e1,
                                          input logic [FW-1:0] f);
        logic [CH+FW+1:0] acc;
        acc = (CH+FW+2)'(e0 * ((FW+1)'(1 << FW) - {1'b0, f}))
            + (CH+FW+2)'(e1 * f)
            + (CH+FW+2)'(1 << (FW - 1));
        return acc[FW +: CH];
    endfunction

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next = state_reg;
        bld_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            tfli_pkg::CTL_IDLE: begin
                if (s_fire && s_data.mode == tfli_pkg::MODE_LOOKUP) begin
                    if (table_valid_reg) begin
                        state_next = tfli_pkg::CTL_SCALE;
                    end else begin
                        bld_start  = 1'b1;
                        state_next = tfli_pkg::CTL_BUILD;
                    end
                end
            end
            tfli_pkg::CTL_BUILD: begin
                if (bld_done) begin
                    state_next = tfli_pkg::CTL_SCALE;
                end
            end
            tfli_pkg::CTL_SCALE: begin
                if (!scale_enable_reg) begin
                    state_next = tfli_pkg::CTL_RANGE;
                end else if (data_maximum_reg == '0) begin
                    state_next = tfli_pkg::CTL_MIX;
                end else begin
                    state_next = tfli_pkg::CTL_DIV_START;
                end
            end
            tfli_pkg::CTL_DIV_START: begin
                div_start  = 1'b1;
                state_next = tfli_pkg::CTL_DIV_WAIT;
            end
            tfli_pkg::CTL_DIV_WAIT: begin
                if (div_done) begin
                    state_next = tfli_pkg::CTL_RANGE;
                end
            end
            tfli_pkg::CTL_RANGE: begin
                if (sample_reg > SW'({eff_top, {FW{1'b0}}})) begin
                    state_next = tfli_pkg::CTL_MIX;
                end else begin
                    state_next = tfli_pkg::CTL_RD_NEXT;
                end
            end
            tfli_pkg::CTL_RD_NEXT: begin
                state_next = tfli_pkg::CTL_CAP_HI;
            end
            tfli_pkg::CTL_CAP_HI: begin
                state_next = tfli_pkg::CTL_MIX;
            end
            tfli_pkg::CTL_MIX: begin
                // wait for the output register to drain
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = tfli_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = tfli_pkg::CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= tfli_pkg::CTL_IDLE;
            top_index_reg    <= tfli_pkg::TOP_RESET;
            scale_enable_reg <= 1'b0;
            data_maximum_reg <= tfli_pkg::DMAX_RESET;
            colour_count_reg <= '0;
            alpha_count_reg  <= '0;
            table_valid_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tfli_pkg::CFG_TOP_INDEX: begin
                        top_index_reg   <= cfg_data[TW-1:0];
                        table_valid_reg <= 1'b0;
                    end
                    tfli_pkg::CFG_SCALE_ENABLE: begin
                        scale_enable_reg <= cfg_data[0];
                    end
                    tfli_pkg::CFG_DATA_MAXIMUM: begin
                        data_maximum_reg <= cfg_data[tfli_pkg::DMAX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (s_fire) begin
                case (s_data.mode)
                    tfli_pkg::MODE_ADD_COLOUR: begin
                        if (cpt_we) begin
                            colour_count_reg <= colour_count_reg + CW'(1);
                        end
                        table_valid_reg <= 1'b0;
                    end
                    tfli_pkg::MODE_ADD_ALPHA: begin
                        if (apt_we) begin
                            alpha_count_reg <= alpha_count_reg + CW'(1);
                        end
                        table_valid_reg <= 1'b0;
                    end
                    tfli_pkg::MODE_CLEAR: begin
                        colour_count_reg <= '0;
                        alpha_count_reg  <= '0;
                        table_valid_reg  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (state_reg == tfli_pkg::CTL_BUILD && bld_done) begin
                table_valid_reg <= 1'b1;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // lookup payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            tfli_pkg::CTL_IDLE: begin
                sample_reg <= SW'(s_data.sample);
            end
            tfli_pkg::CTL_SCALE: begin
                range_reg <= 1'b0;
                // raw sample kept as is when scaling is off
                if (scale_enable_reg) begin
                    sample_reg <= SW'(sample_reg[tfli_pkg::SAMPLE_W-1:0] * top_index_reg);
                end
            end
            tfli_pkg::CTL_DIV_WAIT: begin
                if (div_done) begin
                    sample_reg <= div_q;
                end
            end
            tfli_pkg::CTL_RANGE: begin
                range_reg <= !(sample_reg > SW'({eff_top, {FW{1'b0}}}));
            end
            tfli_pkg::CTL_RD_NEXT: begin
                e0_rgb_reg <= tbl_rgb;
                e0_a_reg   <= tbl_alpha;
            end
            tfli_pkg::CTL_CAP_HI: begin
                e1_rgb_reg <= tbl_rgb;
                e1_a_reg   <= tbl_alpha;
            end
            tfli_pkg::CTL_MIX: begin
                if (out_load) begin
                    if (range_reg) begin
                        m_data_reg.out_red   <= mix(e0_rgb_reg[2*CH +: CH],
                                                    e1_rgb_reg[2*CH +: CH], frac);
                        m_data_reg.out_green <= mix(e0_rgb_reg[CH +: CH],
                                                    e1_rgb_reg[CH +: CH], frac);
                        m_data_reg.out_blue  <= mix(e0_rgb_reg[0 +: CH],
                                                    e1_rgb_reg[0 +: CH], frac);
                        m_data_reg.out_alpha <= mix(e0_a_reg, e1_a_reg, frac);
                        m_data_reg.in_range  <= 1'b1;
                    end else begin
                        m_data_reg <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/tfli_checker.sv
// ----------------------------------------------------------------------------
// Transfer function LUT checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "transfer_function_lut_interp_core_defines.svh"

module tfli_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input tfli_pkg::in_item_t               s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input tfli_pkg::out_item_t              m_data,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [tfli_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [tfli_pkg::CFG_DATA_W-1:0]  cfg_data
);

    `TFLI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    `TFLI_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_data), "stalled result changed")

    `TFLI_ASSERT_NOW(a_oor_zero, m_valid && !m_data.in_range, m_data.out_red == '0 && m_data.out_green == '0 && m_data.out_blue == '0 && m_data.out_alpha == '0, "out-of-range result not zero")

    `TFLI_ASSERT_NEXT(a_no_spurious, s_valid && s_ready && s_data.mode != tfli_pkg::MODE_LOOKUP && !m_valid, !m_valid, "result without a lookup")

endmodule

bind transfer_function_lut_interp_core tfli_checker u_tfli_checker (.*);
